[sv/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // default ring capacity
  localparam int unsigned MAX_VERTICES_DEF = 1024;

  // coordinate widths (degrees times 1e7)
  localparam int unsigned EAST_W  = 32;
  localparam int unsigned NORTH_W = 31;
  localparam int unsigned VERT_W  = EAST_W + NORTH_W;

  // widths of the scan arithmetic
  localparam int unsigned DX_W   = EAST_W + 1;
  localparam int unsigned DY_W   = NORTH_W + 1;
  localparam int unsigned PROD_W = DX_W + DY_W;

  // input word operation
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

endpackage

[sv/point_in_polygon_ray_cast.sv]
// A query reads the ring with one memory read per segment, then drains a three-stage
//   compare pipeline into the result register; an empty ring goes straight to the result.
// Input stalls until the result is loaded, and longer while a previous result waits.
//   Other words are taken in the idle state, which they do not leave.
// Reset (synchronous, rst_n low): ring empty, overflow flag clear, no result pending.
//   Vertex memory contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast
// Vertex ring in a synchronous memory, scanned segment by segment for an
// eastward ray crossing count; the parity gives inside / outside.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_mode,
  input  logic signed [pip_pkg::EAST_W-1:0]  in_east_coord,
  input  logic signed [pip_pkg::NORTH_W-1:0] in_north_coord,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_inside_res,
  output logic                               out_ring_overflow
);

  localparam int unsigned ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

  localparam int unsigned EW = pip_pkg::EAST_W;
  localparam int unsigned NW = pip_pkg::NORTH_W;
  localparam int unsigned VW = pip_pkg::VERT_W;

  // vertex memory: {east, north}
  logic [VW-1:0] mem [MAX_VERTICES];

  // control state
  pip_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              rd_vld_r, rd_first_r, rd_last_r;
  logic              close_pend_r;
  logic              sa_vld_r, sa_last_r;
  logic              sb_vld_r, sb_last_r;
  logic              parity_r;
  logic              out_valid_r;

  // payload registers
  logic signed [EW-1:0] px_r;
  logic signed [NW-1:0] py_r;
  logic [VW-1:0]        mem_q_r, first_r, prev_r;
  logic                 sa_hit_r, sa_dypos_r;
  logic signed [pip_pkg::DX_W-1:0]   sa_dx_r, sa_ex_r;
  logic signed [pip_pkg::DY_W-1:0]   sa_dy_r, sa_ny_r;
  logic                              sb_hit_r, sb_dypos_r;
  logic signed [pip_pkg::PROD_W-1:0] sb_p1_r, sb_p2_r;
  logic                 out_inside_r, out_ovf_r;

  // handshake and sequencer outputs
  pip_pkg::mode_t   mode;
  logic             do_append, do_query, do_clear;
  logic             rd_en, rd_last;
  logic             out_load;
  logic [CNT_W-1:0] cnt_m1;

  assign mode    = pip_pkg::mode_t'(in_mode);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign rd_last = (CNT_W'(rd_addr_r) == cnt_m1);

  // next state and sequencer outputs
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    do_append = 1'b0;
    do_query  = 1'b0;
    do_clear  = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (mode)
            pip_pkg::MODE_APPEND: do_append = 1'b1;
            pip_pkg::MODE_QUERY: begin
              do_query  = 1'b1;
              state_nxt = (cnt_r == '0) ? pip_pkg::ST_OUT : pip_pkg::ST_SCAN;
            end
            pip_pkg::MODE_CLEAR: do_clear = 1'b1;
            default: ;
          endcase
        end
      end
      pip_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_last) state_nxt = pip_pkg::ST_DRAIN;
      end
      pip_pkg::ST_DRAIN: begin
        if (sb_vld_r && sb_last_r) state_nxt = pip_pkg::ST_OUT;
      end
      pip_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = pip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pip_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ring count and sticky overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (do_clear) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (do_append) begin
      if (cnt_r < CNT_W'(MAX_VERTICES)) cnt_r <= cnt_r + CNT_W'(1);
      else                              ovf_r <= 1'b1;
    end
  end

  // vertex memory write on append, registered read during the scan
  always_ff @(posedge clk) begin
    if (do_append && (cnt_r < CNT_W'(MAX_VERTICES))) begin
      mem[cnt_r[ADDR_W-1:0]] <= {in_east_coord, in_north_coord};
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr_r];
    end
  end

  // read address and read-word tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r    <= '0;
      rd_vld_r     <= 1'b0;
      rd_first_r   <= 1'b0;
      rd_last_r    <= 1'b0;
      close_pend_r <= 1'b0;
    end else begin
      if (do_query)   rd_addr_r <= '0;
      else if (rd_en) rd_addr_r <= rd_addr_r + ADDR_W'(1);
      rd_vld_r     <= rd_en;
      rd_first_r   <= rd_en && (rd_addr_r == '0);
      rd_last_r    <= rd_en && rd_last;
      close_pend_r <= rd_vld_r && rd_last_r;
    end
  end

  // query point capture
  always_ff @(posedge clk) begin
    if (do_query) begin
      px_r <= in_east_coord;
      py_r <= in_north_coord;
    end
  end

  // first and previous vertex of the ring walk
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prev_r <= mem_q_r;
      if (rd_first_r) first_r <= mem_q_r;
    end
  end

  // current segment: previous vertex to the word just read, or the closing edge
  logic                 seg_vld;
  logic [VW-1:0]        seg_b;
  logic signed [EW-1:0] ax, bx;
  logic signed [NW-1:0] ay, by;
  logic                 seg_hit;

  assign seg_vld = (rd_vld_r && !rd_first_r) || close_pend_r;
  assign seg_b   = close_pend_r ? first_r : mem_q_r;
  assign ax      = prev_r[VW-1:NW];
  assign ay      = prev_r[NW-1:0];
  assign bx      = seg_b[VW-1:NW];
  assign by      = seg_b[NW-1:0];
  // latitude span holds the point, closed below and open above
  assign seg_hit = ((ay <= py_r) && (by > py_r)) || ((by <= py_r) && (ay > py_r));

  // stage A: differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r  <= 1'b0;
      sa_last_r <= 1'b0;
    end else begin
      sa_vld_r  <= seg_vld;
      sa_last_r <= close_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_hit_r   <= seg_hit;
    sa_dypos_r <= (by > ay);
    sa_dx_r    <= {bx[EW-1], bx} - {ax[EW-1], ax};
    sa_dy_r    <= {by[NW-1], by} - {ay[NW-1], ay};
    sa_ex_r    <= {px_r[EW-1], px_r} - {ax[EW-1], ax};
    sa_ny_r    <= {py_r[NW-1], py_r} - {ay[NW-1], ay};
  end

  // stage B: cross products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r  <= 1'b0;
      sb_last_r <= 1'b0;
    end else begin
      sb_vld_r  <= sa_vld_r;
      sb_last_r <= sa_vld_r && sa_last_r;
    end
  end

  always_ff @(posedge clk) begin
    sb_hit_r   <= sa_hit_r;
    sb_dypos_r <= sa_dypos_r;
    sb_p1_r    <= sa_ex_r * sa_dy_r;
    sb_p2_r    <= sa_ny_r * sa_dx_r;
  end

  // stage C: crossing strictly east of the point toggles the parity
  logic east;
  assign east = sb_dypos_r ? (sb_p1_r < sb_p2_r) : (sb_p2_r < sb_p1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (do_query) begin
      parity_r <= 1'b0;
    end else if (sb_vld_r && sb_hit_r && east) begin
      parity_r <= ~parity_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_inside_r <= parity_r;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_inside_res    = out_inside_r;
  assign out_ring_overflow = out_ovf_r;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point-in-polygon crossing-number block. Words are
// queued up front, sent by a clocked driver and run through an in-bench model
// of the vertex ring; a clocked monitor checks each result word against the
// oldest outstanding verdict. Both sides idle in random bursts, and the result
// side holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RING_CAP    = pip_pkg::MAX_VERTICES_DEF;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 300;

  // mode 3 has no name in the package; the block ignores it
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  localparam logic [31:0] EAST_MIN  = 32'h8000_0000;
  localparam logic [31:0] EAST_MAX  = 32'h7FFF_FFFF;
  localparam logic [30:0] NORTH_MIN = 31'h4000_0000;
  localparam logic [30:0] NORTH_MAX = 31'h3FFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] east;
    logic [30:0] north;
  } word_t;

  typedef struct packed {
    logic in_ring;
    logic over;
  } verdict_t;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode  = '0;
  logic [31:0] in_east_coord  = '0;
  logic [30:0] in_north_coord = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_inside_res;
  logic        out_ring_overflow;

  // stimulus and expectations
  word_t    word_q[$];
  verdict_t verdict_q[$];
  word_t    next_word;
  int       words_total;
  int       calm_start;
  int       words_sent;

  // ring model
  logic [31:0] ring_east  [RING_CAP];
  logic [30:0] ring_north [RING_CAP];
  int          ring_len;
  bit          ring_over;

  // tallies
  int n_append, n_query, n_clear, n_unused;
  int results_seen, overflow_seen, insides_seen;
  int mismatches;

  point_in_polygon_ray_cast #(
    .MAX_VERTICES (RING_CAP)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_east_coord     (in_east_coord),
    .in_north_coord    (in_north_coord),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_inside_res    (out_inside_res),
    .out_ring_overflow (out_ring_overflow)
  );

  // clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------

  // parity of eastward ray crossings; exact, by cross-multiplying
  function automatic bit ring_inside(logic [31:0] pe, logic [30:0] pn);
    logic signed [95:0] px, py, ax, ay, bx, by, dx, dy;
    bit odd;
    bit east;
    int j;
    odd = 1'b0;
    px  = $signed(pe);
    py  = $signed(pn);
    for (int i = 0; i < ring_len; i++) begin
      j  = (i + 1 == ring_len) ? 0 : i + 1;
      ax = $signed(ring_east[i]);
      ay = $signed(ring_north[i]);
      bx = $signed(ring_east[j]);
      by = $signed(ring_north[j]);
      dy = by - ay;
      dx = bx - ax;
      // half-open latitude span, horizontal segments skipped
      if (dy != 0 && ((ay <= py && by > py) || (by <= py && ay > py))) begin
        if (dy > 0) east = (px - ax) * dy < (py - ay) * dx;
        else        east = (py - ay) * dx < (px - ax) * dy;
        if (east) odd = ~odd;
      end
    end
    return odd;
  endfunction

  // one accepted word through the ring model
  function automatic void apply_word(logic [1:0] mode, logic [31:0] e, logic [30:0] n);
    verdict_t v;
    case (mode)
      pip_pkg::MODE_APPEND: begin
        n_append++;
        if (ring_len < RING_CAP) begin
          ring_east[ring_len]  = e;
          ring_north[ring_len] = n;
          ring_len++;
        end else begin
          ring_over = 1'b1;
        end
      end
      pip_pkg::MODE_QUERY: begin
        n_query++;
        v.in_ring = ring_inside(e, n);
        v.over    = ring_over;
        verdict_q = {verdict_q, v};
      end
      pip_pkg::MODE_CLEAR: begin
        n_clear++;
        ring_len  = 0;
        ring_over = 1'b0;
      end
      default: n_unused++;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_word(logic [1:0] m, logic [31:0] e, logic [30:0] n);
    word_t w;
    w.mode  = m;
    w.east  = e;
    w.north = n;
    word_q  = {word_q, w};
  endfunction

  // wide: any bit pattern; otherwise within the stated degree range
  function automatic logic [31:0] any_east(bit wide);
    if (wide) return $urandom();
    return $urandom_range(0, 32'd3600000000) - 32'd1800000000;
  endfunction

  function automatic logic [30:0] any_north(bit wide);
    logic [31:0] r;
    if (wide) r = $urandom();
    else      r = $urandom_range(0, 1800000000) - 32'd900000000;
    return r[30:0];
  endfunction

  // clear, load a ring, then query it; grid rings give plenty of exact ties
  task automatic queue_polygon(int n_vert, int n_q);
    logic [31:0] ve[$];
    logic [30:0] vn[$];
    logic [31:0] e;
    logic [30:0] n;
    int style, pick, k;
    int be, se, bn, sn;
    style = $urandom_range(0, 3);
    be = $signed(any_east(1'b0)) / 2;
    bn = $signed(any_north(1'b0)) / 2;
    se = (style == 0) ? $urandom_range(1, 3) : $urandom_range(1000, 2000000);
    sn = (style == 0) ? $urandom_range(1, 3) : $urandom_range(1000, 2000000);
    push_word(pip_pkg::MODE_CLEAR, $urandom(), any_north(1'b1));
    repeat (n_vert) begin
      if (style < 2) begin
        e = be + se * (int'($urandom_range(0, 12)) - 6);
        n = 31'(bn + sn * (int'($urandom_range(0, 12)) - 6));
      end else begin
        e = any_east(style == 3);
        n = any_north(style == 3);
      end
      ve = {ve, e};
      vn = {vn, n};
      push_word(pip_pkg::MODE_APPEND, e, n);
    end
    repeat (n_q) begin
      pick = $urandom_range(0, 3);
      if (pick == 0 && ve.size() > 0) begin
        // on or next to a vertex
        k = $urandom_range(0, ve.size() - 1);
        e = ve[k] + $urandom_range(0, 2) - 1;
        n = vn[k];
      end else if (pick <= 2 && style < 2) begin
        e = be + se * (int'($urandom_range(0, 12)) - 6) + int'($urandom_range(0, 2)) - 1;
        n = 31'(bn + sn * (int'($urandom_range(0, 12)) - 6));
      end else begin
        e = any_east(style == 3);
        n = any_north(style == 3);
      end
      push_word(pip_pkg::MODE_QUERY, e, n);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sz;
    // directed: empty ring, lone vertex, two vertices at the field extremes
    push_word(pip_pkg::MODE_QUERY, 0, 0);
    push_word(pip_pkg::MODE_APPEND, EAST_MIN, NORTH_MIN);
    push_word(pip_pkg::MODE_QUERY, 0, NORTH_MIN);
    push_word(pip_pkg::MODE_APPEND, EAST_MAX, NORTH_MAX);
    push_word(pip_pkg::MODE_QUERY, 0, 0);
    push_word(pip_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    // small triangle: inside, on the lower latitude, on an edge, outside, top
    push_word(pip_pkg::MODE_APPEND, 0, 0);
    push_word(pip_pkg::MODE_APPEND, 10, 0);
    push_word(pip_pkg::MODE_APPEND, 0, 10);
    push_word(pip_pkg::MODE_QUERY, 2, 2);
    push_word(pip_pkg::MODE_QUERY, 1, 0);
    push_word(pip_pkg::MODE_QUERY, 5, 5);
    push_word(pip_pkg::MODE_QUERY, -1, 5);
    push_word(pip_pkg::MODE_QUERY, 0, 10);
    // unused mode leaves the ring alone
    push_word(MODE_UNUSED, EAST_MAX, NORTH_MIN);
    push_word(pip_pkg::MODE_QUERY, 2, 2);
    push_word(pip_pkg::MODE_CLEAR, 0, 0);
    // square spanning the whole coordinate field
    push_word(pip_pkg::MODE_APPEND, EAST_MIN, NORTH_MIN);
    push_word(pip_pkg::MODE_APPEND, EAST_MAX, NORTH_MIN);
    push_word(pip_pkg::MODE_APPEND, EAST_MAX, NORTH_MAX);
    push_word(pip_pkg::MODE_APPEND, EAST_MIN, NORTH_MAX);
    push_word(pip_pkg::MODE_QUERY, 0, 0);
    push_word(pip_pkg::MODE_QUERY, EAST_MIN, NORTH_MIN);
    push_word(pip_pkg::MODE_QUERY, EAST_MAX, 0);

    // random: mostly well-formed rings, some noise on whatever ring is left
    while (word_q.size() < 545) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 5))
          push_word(2'($urandom_range(0, 3)), $urandom(), any_north(1'b1));
      end else begin
        sz = $urandom_range(0, 99);
        if (sz < 70)      sz = $urandom_range(3, 8);
        else if (sz < 90) sz = $urandom_range(0, 2);
        else              sz = $urandom_range(9, 64);
        queue_polygon(sz, $urandom_range(1, 6));
      end
    end

    // quiet tail, no idling on either side
    calm_start = word_q.size();
    repeat (3) queue_polygon($urandom_range(3, 8), $urandom_range(2, 4));
    words_total = word_q.size();

    // drain, then allow for a stray result from the longest scan
    while (words_sent < words_total || verdict_q.size() != 0) @(posedge clk);
    repeat (RING_CAP + 8) @(posedge clk);

    $display("Covered %0d words: %0d appends, %0d queries, %0d clears, %0d unused",
             words_sent, n_append, n_query, n_clear, n_unused);
    $display("Checked %0d results: %0d inside, %0d with overflow flagged, %0d mismatches",
             results_seen, insides_seen, overflow_seen, mismatches);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  int send_gap = 0;
  int gap_pct  = 20;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // word taken at this edge
      if (in_valid && !in_stall) begin
        apply_word(in_mode, in_east_coord, in_north_coord);
        words_sent++;
      end
      // next word, or a gap; a stalled word is held as it is
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          next_word      = word_q.pop_front();
          in_valid       <= 1'b1;
          in_mode        <= next_word.mode;
          in_east_coord  <= next_word.east;
          in_north_coord <= next_word.north;
          // bursty and quiet stretches alternate
          if (word_q.size() % 48 == 0) gap_pct = $urandom_range(0, 2) * 15;
          if (words_sent < calm_start && $urandom_range(0, 99) < gap_pct)
            send_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  task automatic report_mismatch(string what, logic got, logic want);
    $display("MISMATCH at result %0d: %s got %b want %b", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      // result word taken at this edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_inside_res === 1'b1)    insides_seen++;
        if (out_ring_overflow === 1'b1) overflow_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no query outstanding", out_inside_res, 1'bx);
        end else begin
          want = verdict_q.pop_front();
          if (out_inside_res !== want.in_ring)
            report_mismatch("inside_res", out_inside_res, want.in_ring);
          if (out_ring_overflow !== want.over)
            report_mismatch("ring_overflow", out_ring_overflow, want.over);
        end
      end
      // one long hold-off early on, otherwise short random stalls
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 25) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (words_sent < calm_start && $urandom_range(0, 99) < 8) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no word moving on either channel
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d of %0d words sent",
                 quiet_cycles, words_sent, words_total);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
